>>> sv/gcc_pkg.sv
// gcc_pkg: types, constants and register map shared by the glyph coverage compositor
// depends on nothing
`default_nettype none

package gcc_pkg;

   localparam int MAX_BOX_DIM   = 2048;
   localparam int MAX_GLYPH_DIM = 256;

   localparam int COORD_W = 12;
   localparam int GLYPH_W = 8;
   localparam int POS_W   = COORD_W + 1;
   localparam int DIM_W   = 12;
   localparam int ADDR_W  = 22;
   localparam int RGB_W   = 24;
   localparam int CHAN_W  = 8;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_MASK_MODE  = 3'd0,
      REG_FG_COLOR   = 3'd1,
      REG_BG_COLOR   = 3'd2,
      REG_BOX_WIDTH  = 3'd3,
      REG_BOX_HEIGHT = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic               mask_mode;
      logic [RGB_W-1:0]   fg_color;
      logic [RGB_W-1:0]   bg_color;
      logic [DIM_W-1:0]   box_width;
      logic [DIM_W-1:0]   box_height;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic [GLYPH_W-1:0]        pixel_row;
      logic [GLYPH_W-1:0]        pixel_col;
      logic                      is_mono;
      logic [CHAN_W-1:0]         bitmap_byte;
   } req_type;

   typedef struct packed {
      logic              write_enable;
      logic [ADDR_W-1:0] pixel_address;
      logic [RGB_W-1:0]  pixel_value;
   } rsp_type;

endpackage

`default_nettype wire

>>> sv/gcc_stream_if.sv
// gcc_stream_if: valid/ready channel carrying one payload per transaction
// payload type is set where the channel is instantiated
`default_nettype none

interface gcc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> sv/glyph_coverage_compositor.sv
// glyph_coverage_compositor: coverage-weighted blend of glyph pixels into an rgb888 box
// each accepted transaction goes through the input register, then the result register
// throughput: one transaction per cycle unless stalled, via the input and result registers
// reset: synchronous, active high; empties both stages and restores register defaults
// depends on gcc_pkg, gcc_stream_if, gcc_csr and gcc_pixel
`default_nettype none

module glyph_coverage_compositor
   import gcc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   gcc_stream_if.sink                 req_stream,
   gcc_stream_if.source               rsp_stream,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   cfg_type cfg;
   req_type req_ff;
   logic    req_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_valid_ff;
   logic    advance;
   logic    load_req;

   gcc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gcc_pixel u_pixel (
      .req (req_ff),
      .cfg (cfg),
      .rsp (rsp_in)
   );

   assign advance          = !rsp_valid_ff || rsp_stream.ready;
   assign req_stream.ready = !req_valid_ff || advance;
   assign load_req         = req_stream.valid && req_stream.ready;

   assign rsp_stream.valid   = rsp_valid_ff;
   assign rsp_stream.payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_stream.ready) begin
            req_valid_ff <= req_stream.valid;
         end
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_req) begin
         req_ff <= req_stream.payload;
      end
      if (advance && req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef ASSERT_OFF
   a_drop_is_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.write_enable |->
         (rsp_ff.pixel_address == '0) && (rsp_ff.pixel_value == '0))
      else $error("dropped pixel carries a nonzero address or value");

   a_mask_narrow : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.write_enable && cfg.mask_mode |->
         (rsp_ff.pixel_value[RGB_W-1:CHAN_W] == '0))
      else $error("mask mode result wider than one coverage byte");

   a_load_fills_stage : assert property (@(posedge clock) disable iff (reset)
      load_req |=> req_valid_ff)
      else $error("accepted transaction lost from input stage");

   a_stall_keeps_stage : assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |=> req_valid_ff && $stable(req_ff))
      else $error("input stage changed while result stalled");
`endif

endmodule

`default_nettype wire

>>> sv/gcc_csr.sv
// gcc_csr: apb-style configuration registers of the compositor
// depends on gcc_pkg
`default_nettype none

module gcc_csr
   import gcc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_idx;
   logic          wr_en;

   assign pready  = 1'b1;
   assign reg_idx = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite && pready;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_MASK_MODE:  cfg_in.mask_mode  = pwdata[0];
            REG_FG_COLOR:   cfg_in.fg_color   = pwdata[RGB_W-1:0];
            REG_BG_COLOR:   cfg_in.bg_color   = pwdata[RGB_W-1:0];
            REG_BOX_WIDTH:  cfg_in.box_width  = pwdata[DIM_W-1:0];
            REG_BOX_HEIGHT: cfg_in.box_height = pwdata[DIM_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MASK_MODE:  prdata = CSR_DATA_W'(cfg_ff.mask_mode);
         REG_FG_COLOR:   prdata = CSR_DATA_W'(cfg_ff.fg_color);
         REG_BG_COLOR:   prdata = CSR_DATA_W'(cfg_ff.bg_color);
         REG_BOX_WIDTH:  prdata = CSR_DATA_W'(cfg_ff.box_width);
         REG_BOX_HEIGHT: prdata = CSR_DATA_W'(cfg_ff.box_height);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mask_mode  <= 1'b0;
         cfg_ff.fg_color   <= {RGB_W{1'b1}};
         cfg_ff.bg_color   <= '0;
         cfg_ff.box_width  <= DIM_W'(1);
         cfg_ff.box_height <= DIM_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/gcc_blend.sv
// gcc_blend: one 8-bit channel blended by coverage, (f*c + b*(255-c))/255 truncated
// depends on gcc_pkg
`default_nettype none

module gcc_blend
   import gcc_pkg::*;
(
   input  wire logic [CHAN_W-1:0] fg,
   input  wire logic [CHAN_W-1:0] bg,
   input  wire logic [CHAN_W-1:0] cov,
   output logic [CHAN_W-1:0]      chan
);

   logic [CHAN_W-1:0]   cov_inv;
   logic [2*CHAN_W-1:0] sum;
   logic [2*CHAN_W:0]   approx;

   // divide by 255 as (v + (v >> 8) + 1) >> 8, exact for v up to 255*255
   assign cov_inv = ~cov;
   assign sum     = (2*CHAN_W)'(fg) * (2*CHAN_W)'(cov) + (2*CHAN_W)'(bg) * (2*CHAN_W)'(cov_inv);
   assign approx  = (2*CHAN_W+1)'(sum) + (2*CHAN_W+1)'(sum >> CHAN_W) + (2*CHAN_W+1)'(1);
   assign chan    = approx[2*CHAN_W-1:CHAN_W];

endmodule

`default_nettype wire

>>> sv/gcc_pixel.sv
// gcc_pixel: clip, coverage, address and colour of one glyph pixel
// depends on gcc_pkg and gcc_blend
`default_nettype none

module gcc_pixel
   import gcc_pkg::*;
(
   input  wire req_type  req,
   input  wire cfg_type  cfg,
   output rsp_type       rsp
);

   logic signed [POS_W-1:0] x_pos;
   logic signed [POS_W-1:0] y_pos;
   logic [DIM_W-1:0]        w_sat;
   logic [DIM_W-1:0]        h_sat;
   logic [CHAN_W-1:0]       cov;
   logic                    glyph_ok;
   logic                    in_box;
   logic                    keep;
   logic [2*DIM_W-1:0]      addr_full;
   logic [RGB_W-1:0]        blended;

   assign x_pos = POS_W'(req.origin_x) + POS_W'($signed({1'b0, req.pixel_col}));
   assign y_pos = POS_W'(req.origin_y) + POS_W'($signed({1'b0, req.pixel_row}));

   assign w_sat = (32'(cfg.box_width) > MAX_BOX_DIM)  ? DIM_W'(MAX_BOX_DIM) : cfg.box_width;
   assign h_sat = (32'(cfg.box_height) > MAX_BOX_DIM) ? DIM_W'(MAX_BOX_DIM) : cfg.box_height;

   assign glyph_ok = (32'(req.pixel_row) < MAX_GLYPH_DIM) &&
                     (32'(req.pixel_col) < MAX_GLYPH_DIM);

   assign in_box = !x_pos[POS_W-1] && !y_pos[POS_W-1] &&
                   (x_pos[DIM_W-1:0] < w_sat) && (y_pos[DIM_W-1:0] < h_sat);

   // mono bitmaps are msb first
   assign cov = req.is_mono
              ? {CHAN_W{req.bitmap_byte[3'(CHAN_W-1) - req.pixel_col[2:0]]}}
              : req.bitmap_byte;

   assign keep = glyph_ok && in_box && (cov != '0);

   assign addr_full = y_pos[DIM_W-1:0] * w_sat + (2*DIM_W)'(x_pos[DIM_W-1:0]);

   gcc_blend u_blend_r (
      .fg   (cfg.fg_color[3*CHAN_W-1:2*CHAN_W]),
      .bg   (cfg.bg_color[3*CHAN_W-1:2*CHAN_W]),
      .cov  (cov),
      .chan (blended[3*CHAN_W-1:2*CHAN_W])
   );

   gcc_blend u_blend_g (
      .fg   (cfg.fg_color[2*CHAN_W-1:CHAN_W]),
      .bg   (cfg.bg_color[2*CHAN_W-1:CHAN_W]),
      .cov  (cov),
      .chan (blended[2*CHAN_W-1:CHAN_W])
   );

   gcc_blend u_blend_b (
      .fg   (cfg.fg_color[CHAN_W-1:0]),
      .bg   (cfg.bg_color[CHAN_W-1:0]),
      .cov  (cov),
      .chan (blended[CHAN_W-1:0])
   );

   always_comb begin
      rsp = '0;
      if (keep) begin
         rsp.write_enable  = 1'b1;
         rsp.pixel_address = addr_full[ADDR_W-1:0];
         rsp.pixel_value   = cfg.mask_mode ? RGB_W'(cov) : blended;
      end
   end

endmodule

`default_nettype wire
